// ----- hdl/ima_adpcm_stereo_block_decoder_macros.svh -----
// assertion helpers for the checker file
`ifndef IMA_ADPCM_STEREO_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_STEREO_BLOCK_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IMADEC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IMADEC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/imadec_pkg.sv -----
package imadec_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 10;
    localparam int IDX_W    = 7;
    localparam int STEP_W   = 15;

    localparam logic [IDX_W-1:0] MAX_INDEX = 7'd88;

    typedef enum logic [1:0] {
        HDR_PRED_LO,
        HDR_PRED_HI,
        HDR_INDEX,
        HDR_RESERVED
    } hdr_slot_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel_id;
        logic [FRAME_W-1:0]         frame_number;
        logic                       last_of_block;
        logic                       bad_index;
    } imadec_result_t;

    localparam logic signed [4:0] INDEX_DELTA [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

endpackage

// ----- hdl/imadec_in_if.sv -----
interface imadec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_start;

    modport source (output valid, output data_byte, output block_start, input ready);
    modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

// ----- hdl/imadec_out_if.sv -----
interface imadec_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               channel_id;
    logic [9:0]         frame_number;
    logic               last_of_block;
    logic               bad_index;

    modport source (output valid, output sample, output channel_id, output frame_number,
                    output last_of_block, output bad_index, input ready);
    modport sink   (input valid, input sample, input channel_id, input frame_number,
                    input last_of_block, input bad_index, output ready);
endinterface

// ----- hdl/imadec_nibble.sv -----
module imadec_nibble (
    input  logic signed [15:0] pred,
    input  logic [6:0]         idx,
    input  logic [3:0]         code,
    output logic signed [15:0] pred_next,
    output logic [6:0]         idx_next
);
    import imadec_pkg::*;

    logic [IDX_W-1:0]  idx_c;
    logic [STEP_W-1:0] step;
    logic [16:0]       diff;
    logic signed [17:0] pred_x;
    logic signed [17:0] diff_x;
    logic signed [17:0] sum;
    logic signed [8:0]  idx_sum;
    logic signed [4:0]  delta;

    always_comb
    begin
        idx_c = (idx > MAX_INDEX) ? MAX_INDEX : idx;
        step  = STEP_TABLE[idx_c];
        diff  = 17'(step >> 3)
              + (code[0] ? 17'(step >> 2) : 17'd0)
              + (code[1] ? 17'(step >> 1) : 17'd0)
              + (code[2] ? 17'(step)      : 17'd0);
        pred_x = {{2{pred[15]}}, pred};
        diff_x = $signed({1'b0, diff});
        sum    = code[3] ? (pred_x - diff_x) : (pred_x + diff_x);

        if (sum > 18'sd32767)
        begin
            pred_next = 16'sh7FFF;
        end
        else if (sum < -18'sd32768)
        begin
            pred_next = 16'sh8000;
        end
        else
        begin
            pred_next = sum[15:0];
        end

        delta   = INDEX_DELTA[code[2:0]];
        idx_sum = $signed({2'b00, idx_c}) + $signed({{4{delta[4]}}, delta});
        if (idx_sum < 9'sd0)
        begin
            idx_next = '0;
        end
        else if (idx_sum > $signed({2'b00, MAX_INDEX}))
        begin
            idx_next = MAX_INDEX;
        end
        else
        begin
            idx_next = idx_sum[6:0];
        end
    end
endmodule

// ----- hdl/ima_adpcm_stereo_block_decoder.sv -----
// stereo ima adpcm block decoder, one encoded byte per input item
// an accepted byte is registered in the input register, decoded from there into a
// four-entry result queue once the queue has room, and its results show on pcm_chan from the queue
// throughput: one byte per cycle while the queue holds two or fewer results;
// a data byte gives two results, and these leave in turn through the single result port
// reset: predictors, step indexes, block position and queue clear to zero

module ima_adpcm_stereo_block_decoder #(
    parameter int BLOCK_BYTES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    imadec_in_if.sink     code_chan,
    imadec_out_if.source  pcm_chan
);
    import imadec_pkg::*;

    localparam int POS_W      = $clog2(BLOCK_BYTES + 1);
    localparam int GROUPS     = (BLOCK_BYTES - 8) / 8;
    localparam int DATA_BYTES = GROUPS * 8;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       accept;
    logic       fire;

    // decoder state
    logic signed [SAMPLE_W-1:0] pred_reg [2];
    logic signed [SAMPLE_W-1:0] pred_next [2];
    logic [IDX_W-1:0]           idx_reg [2];
    logic [IDX_W-1:0]           idx_next [2];
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [7:0]                 low_reg, low_next;
    logic                       abort_reg, abort_next;

    // result queue
    imadec_result_t    q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;

    // decode path
    logic [POS_W-1:0]           pos_eff;
    logic                       abort_eff;
    logic [POS_W-1:0]           d;
    logic [POS_W-1:0]           fbase;
    logic [POS_W-1:0]           frame0;
    logic [POS_W-1:0]           frame1;
    logic                       ch;
    logic signed [SAMPLE_W-1:0] nib0_pred, nib1_pred;
    logic [IDX_W-1:0]           nib0_idx, nib1_idx;
    logic [1:0]                 n_wr;
    imadec_result_t             res0, res1;

    assign accept         = code_chan.valid && code_chan.ready;
    assign fire           = in_vld_reg && (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign code_chan.ready = !in_vld_reg || fire;
    assign in_vld_next    = accept ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    assign pos_eff   = in_start_reg ? '0 : pos_reg;
    assign abort_eff = in_start_reg ? 1'b0 : abort_reg;
    assign ch        = pos_eff[2];
    assign d         = pos_eff - POS_W'(8);
    assign fbase     = {d[POS_W-1:3], 3'b000} | {{(POS_W-3){1'b0}}, d[1:0], 1'b0};
    assign frame0    = fbase + POS_W'(1);
    assign frame1    = fbase + POS_W'(2);

    imadec_nibble u_nib_lo (
        .pred      (pred_reg[ch]),
        .idx       (idx_reg[ch]),
        .code      (in_byte_reg[3:0]),
        .pred_next (nib0_pred),
        .idx_next  (nib0_idx)
    );

    imadec_nibble u_nib_hi (
        .pred      (nib0_pred),
        .idx       (nib0_idx),
        .code      (in_byte_reg[7:4]),
        .pred_next (nib1_pred),
        .idx_next  (nib1_idx)
    );

    always_comb
    begin
        pred_next  = pred_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        low_next   = low_reg;
        abort_next = abort_reg;
        n_wr       = 2'd0;
        res0       = '0;
        res1       = '0;
        res0.channel_id = ch;
        res1.channel_id = ch;

        if (fire)
        begin
            pos_next   = pos_eff;
            abort_next = abort_eff;
            if (!abort_eff && (pos_eff < POS_W'(BLOCK_BYTES)))
            begin
                pos_next = pos_eff + POS_W'(1);
                if (pos_eff < POS_W'(8))
                begin
                    unique case (hdr_slot_t'(pos_eff[1:0]))
                        HDR_PRED_LO:
                        begin
                            low_next = in_byte_reg;
                        end
                        HDR_PRED_HI:
                        begin
                            pred_next[ch] = {in_byte_reg, low_reg};
                        end
                        HDR_INDEX:
                        begin
                            n_wr = 2'd1;
                            if (in_byte_reg > {1'b0, MAX_INDEX})
                            begin
                                abort_next     = 1'b1;
                                res0.bad_index = 1'b1;
                            end
                            else
                            begin
                                idx_next[ch] = in_byte_reg[IDX_W-1:0];
                                res0.sample  = pred_reg[ch];
                            end
                        end
                        HDR_RESERVED:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (d < POS_W'(DATA_BYTES))
                begin
                    n_wr               = 2'd2;
                    pred_next[ch]      = nib1_pred;
                    idx_next[ch]       = nib1_idx;
                    res0.sample        = nib0_pred;
                    res0.frame_number  = FRAME_W'(frame0);
                    res1.sample        = nib1_pred;
                    res1.frame_number  = FRAME_W'(frame1);
                    res1.last_of_block = (d == POS_W'(DATA_BYTES - 1));
                end
            end
        end
    end

    // result queue control
    assign pop         = pcm_chan.valid && pcm_chan.ready;
    assign wr_ptr_inc  = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(n_wr);
    assign rd_ptr_next = pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + QCNT_W'(n_wr) - QCNT_W'(pop);

    assign pcm_chan.valid         = (cnt_reg != '0);
    assign pcm_chan.sample        = q_mem[rd_ptr_reg].sample;
    assign pcm_chan.channel_id    = q_mem[rd_ptr_reg].channel_id;
    assign pcm_chan.frame_number  = q_mem[rd_ptr_reg].frame_number;
    assign pcm_chan.last_of_block = q_mem[rd_ptr_reg].last_of_block;
    assign pcm_chan.bad_index     = q_mem[rd_ptr_reg].bad_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            pred_reg[0] <= '0;
            pred_reg[1] <= '0;
            idx_reg[0]  <= '0;
            idx_reg[1]  <= '0;
            pos_reg     <= '0;
            low_reg     <= '0;
            abort_reg   <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            pred_reg   <= pred_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            low_reg    <= low_next;
            abort_reg  <= abort_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= code_chan.data_byte;
            in_start_reg <= code_chan.block_start;
        end
        if (n_wr != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (n_wr == 2'd2)
        begin
            q_mem[wr_ptr_inc] <= res1;
        end
    end
endmodule

// ----- hdl/imadec_checker.sv -----
`include "ima_adpcm_stereo_block_decoder_macros.svh"

module imadec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] sample,
    input logic        channel_id,
    input logic [9:0]  frame_number,
    input logic        last_of_block,
    input logic        bad_index
);
    // a stalled result keeps its payload
    `IMADEC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(frame_number) && $stable(channel_id) && $stable(bad_index), "result changed while stalled")

    // an error item carries no sample and sits at frame zero
    `IMADEC_ASSERT_IMP(a_bad_clean, out_valid && bad_index, sample == 16'd0 && frame_number == 10'd0 && !last_of_block, "error item has payload")

    // the block closes on the right channel with a good sample
    `IMADEC_ASSERT_IMP(a_last_right, out_valid && last_of_block, channel_id && !bad_index && frame_number != 10'd0, "last item not on right channel")
endmodule

bind ima_adpcm_stereo_block_decoder imadec_checker u_imadec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (pcm_chan.valid),
    .out_ready     (pcm_chan.ready),
    .sample        (pcm_chan.sample),
    .channel_id    (pcm_chan.channel_id),
    .frame_number  (pcm_chan.frame_number),
    .last_of_block (pcm_chan.last_of_block),
    .bad_index     (pcm_chan.bad_index)
);

// ----- verif/tb_ima_adpcm_stereo_block_decoder.sv -----
`timescale 1ns / 1ps

module tb_ima_adpcm_stereo_block_decoder;
    import imadec_pkg::*;

    localparam int BLOCK_LEN   = 1024;
    localparam int DATA_GROUPS = (BLOCK_LEN - 8) / 8;
    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_LEN    = 300;
    localparam bit RIGHT_CH    = 1'b1;

    class pcm_scoreboard;
        imadec_result_t     pending_pcm[$];
        logic signed [15:0] pred_q[2];
        logic [6:0]         index_q[2];
        int unsigned        byte_pos;
        logic [7:0]         pred_lo;
        bit                 aborted;
        int                 failures;
        int                 samples_checked;
        int                 bad_seen;
        int                 ends_seen;

        function new();
            pred_q[0] = '0;
            pred_q[1] = '0;
            index_q[0] = '0;
            index_q[1] = '0;
            byte_pos = 0;
            pred_lo = '0;
            aborted = 0;
            failures = 0;
            samples_checked = 0;
            bad_seen = 0;
            ends_seen = 0;
        endfunction

        function void queue_pcm(logic signed [15:0] s, bit ch, int unsigned fr, bit last,
                                bit bad);
            imadec_result_t r;
            r.sample = s;
            r.channel_id = ch;
            r.frame_number = 10'(fr);
            r.last_of_block = last;
            r.bad_index = bad;
            pending_pcm.push_back(r);
        endfunction

        function logic signed [15:0] decode_nibble(bit ch, logic [3:0] code);
            int step;
            int diff;
            int acc;
            int nidx;
            step = int'(STEP_TABLE[index_q[ch]]);
            diff = step >> 3;
            if (code[0]) diff += step >> 2;
            if (code[1]) diff += step >> 1;
            if (code[2]) diff += step;
            acc = pred_q[ch];
            acc = code[3] ? acc - diff : acc + diff;
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            pred_q[ch] = 16'(acc);
            nidx = int'(index_q[ch]) + int'(INDEX_DELTA[code[2:0]]);
            if (nidx < 0) nidx = 0;
            if (nidx > int'(MAX_INDEX)) nidx = int'(MAX_INDEX);
            index_q[ch] = 7'(nidx);
            return pred_q[ch];
        endfunction

        // returns 1 when the byte is taken into the block, 0 when ignored
        function bit accept_byte(logic [7:0] b, logic start);
            int unsigned p;
            int unsigned d;
            int unsigned grp;
            int unsigned b3;
            int unsigned fr;
            bit ch;
            logic signed [15:0] s0;
            logic signed [15:0] s1;
            if (start) begin
                byte_pos = 0;
                aborted = 0;
            end
            if (aborted || byte_pos >= BLOCK_LEN) return 0;
            p = byte_pos;
            byte_pos++;
            if (p < 8) begin
                ch = p[2];
                case (hdr_slot_t'(p[1:0]))
                    HDR_PRED_LO: pred_lo = b;
                    HDR_PRED_HI: pred_q[ch] = {b, pred_lo};
                    HDR_INDEX:
                    begin
                        if (b > MAX_INDEX) begin
                            aborted = 1;
                            queue_pcm('0, ch, 0, 1'b0, 1'b1);
                        end
                        else begin
                            index_q[ch] = b[6:0];
                            queue_pcm(pred_q[ch], ch, 0, 1'b0, 1'b0);
                        end
                    end
                    default: ;
                endcase
                return 1;
            end
            d = p - 8;
            if (d >= DATA_GROUPS * 8) return 0;
            grp = d >> 3;
            ch = d[2];
            b3 = d & 3;
            fr = 1 + grp * 8 + b3 * 2;
            s0 = decode_nibble(ch, b[3:0]);
            s1 = decode_nibble(ch, b[7:4]);
            queue_pcm(s0, ch, fr, 1'b0, 1'b0);
            queue_pcm(s1, ch, fr + 1,
                      (ch == RIGHT_CH) && (b3 == 3) && (grp == DATA_GROUPS - 1), 1'b0);
            return 1;
        endfunction

        function void check_pcm(imadec_result_t got);
            imadec_result_t want;
            samples_checked++;
            if (got.bad_index) bad_seen++;
            if (got.last_of_block) ends_seen++;
            if (pending_pcm.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pcm item: sample %0d ch %0d frame %0d last %0b bad %0b",
                             got.sample, got.channel_id, got.frame_number,
                             got.last_of_block, got.bad_index);
                return;
            end
            want = pending_pcm.pop_front();
            if (got.sample !== want.sample || got.channel_id !== want.channel_id ||
                got.frame_number !== want.frame_number ||
                got.last_of_block !== want.last_of_block ||
                got.bad_index !== want.bad_index) begin
                failures++;
                if (failures <= 10) begin
                    $display("pcm mismatch: expected sample %0d ch %0d frame %0d last %0b bad %0b",
                             want.sample, want.channel_id, want.frame_number,
                             want.last_of_block, want.bad_index);
                    $display("              actual   sample %0d ch %0d frame %0d last %0b bad %0b",
                             got.sample, got.channel_id, got.frame_number,
                             got.last_of_block, got.bad_index);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    imadec_in_if  code_if();
    imadec_out_if pcm_if();

    ima_adpcm_stereo_block_decoder #(
        .BLOCK_BYTES(BLOCK_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .code_chan(code_if),
        .pcm_chan (pcm_if)
    );

    pcm_scoreboard sb;
    int            pcm_hold_cycles;
    int            cycle_count;
    int            work_items;
    int            block_count;
    bit            tx_calm;
    bit            tx_offering;
    logic [7:0]    dir_bytes[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin : pcm_monitor
        imadec_result_t got;
        if (rst_n && pcm_if.valid && pcm_if.ready) begin
            got.sample = pcm_if.sample;
            got.channel_id = pcm_if.channel_id;
            got.frame_number = pcm_if.frame_number;
            got.last_of_block = pcm_if.last_of_block;
            got.bad_index = pcm_if.bad_index;
            sb.check_pcm(got);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'(MAX_INDEX);
        if (r < 25) return 8'($urandom_range(89, 255));
        return 8'($urandom_range(0, 88));
    endfunction

    // pcm receiver
    initial
    begin
        int  stall_left;
        int  mode_timer;
        bit  rx_calm;
        stall_left = 0;
        mode_timer = 0;
        rx_calm = 0;
        pcm_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            mode_timer++;
            if (mode_timer == 256) begin
                mode_timer = 0;
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (pcm_hold_cycles > 0) begin
                pcm_if.ready <= 1'b0;
                pcm_hold_cycles--;
            end
            else if (stall_left > 0) begin
                pcm_if.ready <= 1'b0;
                stall_left--;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 30) begin
                pcm_if.ready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                           : $urandom_range(9, 39);
            end
            else begin
                pcm_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        code_if.valid <= 1'b1;
        code_if.data_byte <= b;
        code_if.block_start <= start;
        tx_offering = 1;
        do @(posedge clk); while (!code_if.ready);
        if (sb.accept_byte(b, start)) work_items++;
        @(negedge clk);
    endtask

    task automatic tx_rest();
        if (tx_offering) begin
            code_if.valid <= 1'b0;
            tx_offering = 0;
        end
    endtask

    task automatic tx_gap();
        int n;
        n = pick_gap();
        if (tx_calm || n == 0) return;
        tx_rest();
        repeat (n) @(negedge clk);
    endtask

    task automatic send_seq(input bit first_start);
        foreach (dir_bytes[i]) begin
            send_byte(dir_bytes[i], first_start && i == 0);
            tx_gap();
        end
    endtask

    task automatic send_hdr(input logic first, input logic [15:0] pv, input logic [7:0] ix);
        send_byte(pv[7:0], first);
        tx_gap();
        send_byte(pv[15:8], 1'b0);
        tx_gap();
        send_byte(ix, 1'b0);
        tx_gap();
        send_byte(8'($urandom), 1'b0);
        tx_gap();
    endtask

    task automatic random_block(input int n_data, input bit can_break);
        logic [7:0] lix;
        logic [7:0] rix;
        lix = can_break ? pick_index() : 8'($urandom_range(0, 88));
        rix = can_break ? pick_index() : 8'($urandom_range(0, 88));
        block_count++;
        send_hdr(1'b1, 16'($urandom), lix);
        send_hdr(1'b0, 16'($urandom), rix);
        for (int i = 0; i < n_data; i++) begin
            send_byte(8'($urandom), can_break && ($urandom_range(0, 199) == 0));
            tx_gap();
        end
    endtask

    initial
    begin
        int blk;
        sb = new();
        pcm_hold_cycles = 0;
        cycle_count = 0;
        work_items = 0;
        block_count = 0;
        tx_calm = 0;
        tx_offering = 0;
        rst_n = 1'b0;
        code_if.valid = 1'b0;
        code_if.data_byte = '0;
        code_if.block_start = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first block without a block start, saturating headers, all sixteen codes
        dir_bytes = '{8'h00, 8'h80, 8'd88, 8'hA5, 8'hFF, 8'h7F, 8'd88, 8'h5A,
                      8'h0F, 8'h21, 8'h43, 8'h65, 8'h87, 8'hA9, 8'hCB, 8'hED};
        send_seq(1'b0);
        // bad index on the left header
        dir_bytes = '{8'h34, 8'h12, 8'd89};
        send_seq(1'b1);
        // good left header with index 0, bad right index, then an ignored byte
        dir_bytes = '{8'h00, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h3C};
        send_seq(1'b1);
        block_count = 3;

        blk = 0;
        while (work_items < ITEM_TARGET) begin
            blk++;
            tx_calm = ($urandom_range(0, 3) == 0);
            if (blk == 2) pcm_hold_cycles = HOLD_LEN;
            if (blk == 5 || $urandom_range(0, 7) == 0) begin
                tx_rest();
                do @(negedge clk); while (sb.pending_pcm.size() != 0);
            end
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                    tx_gap();
                end
            end
            if (blk == 3)
                random_block(BLOCK_LEN - 8 + $urandom_range(1, 6), 1'b0);
            else
                random_block($urandom_range(0, 48), 1'b1);
        end

        tx_rest();
        while (sb.pending_pcm.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);

        $display("sent %0d decoded bytes over %0d blocks in %0d cycles", work_items,
                 block_count, cycle_count);
        $display("checked %0d pcm items, %0d index errors, %0d block ends, %0d failures",
                 sb.samples_checked, sb.bad_seen, sb.ends_seen, sb.failures);
        if (sb.failures == 0 && sb.pending_pcm.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
